// ===== rtl/wlwa_pkg.sv =====
// Types and constants shared by the write latency window average block.
package wlwa_pkg;

    localparam int SEC_W     = 12;
    localparam int USEC_W    = 20;
    localparam int HELD_W    = 4;
    localparam int SAMPLE_W  = 32;
    localparam int DIVISOR_W = 20;

    localparam logic [USEC_W-1:0]   USEC_PER_SEC = 20'd1000000;
    localparam logic [SAMPLE_W-1:0] MAX_AVG_USEC = 32'd4095999999;

    // The mean is split as 1000000 = 64 * 15625, the second factor by a reciprocal multiply.
    localparam int SPLIT_PRE_SHIFT = 6;
    localparam int SPLIT_IN_W      = SAMPLE_W - SPLIT_PRE_SHIFT;
    localparam int RECIP_W         = 27;
    localparam int RECIP_SHIFT     = 40;
    localparam logic [RECIP_W-1:0] RECIP_USEC = 27'd70368745;

    typedef struct packed {
        logic [SEC_W-1:0]  elapsed_sec;
        logic [USEC_W-1:0] elapsed_usec;
        logic              measured_ok;
    } wlwa_in_t;

    typedef struct packed {
        logic [SEC_W-1:0]  average_sec;
        logic [USEC_W-1:0] average_usec;
        logic [HELD_W-1:0] samples_held;
    } wlwa_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIV_AVG,
        ST_WAIT_AVG,
        ST_SPLIT,
        ST_OUT
    } wlwa_state_t;

endpackage

// ===== rtl/wlwa_ring.sv =====
// Sample ring memory with one write port and one registered read port.
module wlwa_ring import wlwa_pkg::*; #(
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  logic [SAMPLE_W-1:0] wr_data,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output logic [SAMPLE_W-1:0] rd_data
);

    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/wlwa_div.sv =====
// Restoring divider that resolves one quotient bit per cycle.
module wlwa_div import wlwa_pkg::*; #(
    parameter int DIVIDEND_W = 35
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] q_reg, q_next;
    logic [DIVISOR_W-1:0]  r_reg, r_next;
    logic [DIVISOR_W-1:0]  d_reg, d_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    trial;

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {r_reg, q_reg[DIVIDEND_W-1]};
        trial     = shifted - {1'b0, d_reg};
        if (start) begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = CNT_W'(DIVIDEND_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[DIVISOR_W]) begin
                r_next = trial[DIVISOR_W-1:0];
                q_next = {q_reg[DIVIDEND_W-2:0], 1'b1};
            end else begin
                r_next = shifted[DIVISOR_W-1:0];
                q_next = {q_reg[DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== rtl/write_latency_window_average.sv =====
// Top level of the write latency window average block.
// Each accepted word passes through the update, divider start, divider wait, split and output
// states in order; the next word is taken only once the block is back in idle.
// The mean comes from the one-bit-per-cycle divider; the split into seconds and
// microseconds is a reciprocal multiply. A word is taken while a result waits.
// Synchronous active-low reset clears the count, slot, total and current average.
module write_latency_window_average import wlwa_pkg::*; #(
    parameter int HISTORY_DEPTH = 8
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  wlwa_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output wlwa_out_t m_data
);

    localparam int SLOT_W  = $clog2(HISTORY_DEPTH);
    localparam int FILL_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int TOTAL_W = SAMPLE_W + SLOT_W;

    wlwa_state_t state_reg, state_next;

    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [SAMPLE_W-1:0] avg_reg, avg_next;
    logic [SAMPLE_W-1:0] sample_reg, sample_next;
    logic [SEC_W-1:0]    quot_reg, quot_next;
    logic                m_valid_reg, m_valid_next;
    wlwa_out_t           m_data_reg, m_data_next;

    logic                full;
    logic                accept;
    logic [SAMPLE_W-1:0] rd_data;
    logic                ring_wr;
    logic [SAMPLE_W-1:0] measured;

    logic [SPLIT_IN_W+RECIP_W-1:0] split_prod;
    logic [SAMPLE_W-1:0]           split_rem;

    logic                div_start;
    logic [TOTAL_W-1:0]  div_dividend;
    logic [DIVISOR_W-1:0] div_divisor;
    logic                div_done;
    logic [TOTAL_W-1:0]  div_quot;

    assign full     = (fill_reg == FILL_W'(HISTORY_DEPTH));
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign measured = SAMPLE_W'(s_data.elapsed_sec) * SAMPLE_W'(USEC_PER_SEC)
                    + SAMPLE_W'(s_data.elapsed_usec);

    assign split_prod = avg_reg[SAMPLE_W-1:SPLIT_PRE_SHIFT] * RECIP_USEC;
    assign split_rem  = avg_reg - SAMPLE_W'(quot_reg) * SAMPLE_W'(USEC_PER_SEC);

    wlwa_ring #(
        .DEPTH  (HISTORY_DEPTH),
        .ADDR_W (SLOT_W)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ring_wr),
        .wr_addr (slot_reg),
        .wr_data (sample_reg),
        .rd_en   (accept),
        .rd_addr (slot_reg),
        .rd_data (rd_data)
    );

    wlwa_div #(
        .DIVIDEND_W (TOTAL_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quot)
    );

    always_comb begin
        state_next   = state_reg;
        slot_next    = slot_reg;
        fill_next    = fill_reg;
        total_next   = total_reg;
        avg_next     = avg_reg;
        sample_next  = sample_reg;
        quot_next    = quot_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        ring_wr      = 1'b0;
        div_start    = 1'b0;
        div_dividend = total_reg;
        div_divisor  = DIVISOR_W'(fill_reg);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    sample_next = s_data.measured_ok ? measured : avg_reg;
                    state_next  = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                ring_wr    = 1'b1;
                total_next = total_reg + TOTAL_W'(sample_reg)
                           - (full ? TOTAL_W'(rd_data) : TOTAL_W'(0));
                if (!full) begin
                    fill_next = fill_reg + 1'b1;
                end
                if (slot_reg == SLOT_W'(HISTORY_DEPTH - 1)) begin
                    slot_next = '0;
                end else begin
                    slot_next = slot_reg + 1'b1;
                end
                state_next = ST_DIV_AVG;
            end
            ST_DIV_AVG: begin
                div_start  = 1'b1;
                state_next = ST_WAIT_AVG;
            end
            ST_WAIT_AVG: begin
                if (div_done) begin
                    if (div_quot > TOTAL_W'(MAX_AVG_USEC)) begin
                        avg_next = MAX_AVG_USEC;
                    end else begin
                        avg_next = div_quot[SAMPLE_W-1:0];
                    end
                    state_next = ST_SPLIT;
                end
            end
            ST_SPLIT: begin
                quot_next  = split_prod[RECIP_SHIFT +: SEC_W];
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next             = 1'b1;
                    m_data_next.average_sec  = quot_reg;
                    m_data_next.average_usec = split_rem[USEC_W-1:0];
                    m_data_next.samples_held = HELD_W'(fill_reg);
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            slot_reg    <= '0;
            fill_reg    <= '0;
            total_reg   <= '0;
            avg_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            slot_reg    <= slot_next;
            fill_reg    <= fill_next;
            total_reg   <= total_next;
            avg_reg     <= avg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg <= sample_next;
        quot_reg   <= quot_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
